// ===== rtl/core/gba_pkg.sv =====
// gba_pkg: shared types and constants for the grouped bitmap allocator
// used by gba_find, grouped_bitmap_allocator and gba_checker; depends on nothing

package gba_pkg;

    localparam int NUM_W     = 18;
    localparam int STATUS_W  = 2;
    localparam int GIDX_W    = 4;
    localparam int CNT_W     = 14;
    localparam int BPG_W     = 14;
    localparam int NGRP_W    = 5;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 64;
    localparam int OFF_W     = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [BPG_W-1:0]  BPG_RESET  = 14'd8192;
    localparam logic [NGRP_W-1:0] NGRP_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_GROUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE    = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE        = 2'd3;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] pos;
    } t_find_res;

endpackage

// ===== rtl/core/gba_ram.sv =====
// gba_ram: single port synchronous memory, registered read
// depends on nothing; used for the bitmap words and the group counters

module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/core/gba_find.sv =====
// gba_find: lowest clear bit of a bitmap word inside a window of positions
// depends on gba_pkg

module gba_find
    import gba_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic [OFF_W-1:0]  i_off,
    input  logic [BPG_W:0]    i_rem,
    output t_find_res         o_res
);

    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] lowest;
    logic [OFF_W-1:0]  pos;

    always_comb begin
        for (int p = 0; p < WORD_W; p++) begin
            cand[p] = !i_word[p] && (OFF_W'(p) >= i_off)
                      && ((BPG_W + 1)'(OFF_W'(p) - i_off) < i_rem);
        end
    end

    assign lowest = cand & (~cand + WORD_W'(1));

    always_comb begin
        pos = '0;
        for (int p = 0; p < WORD_W; p++) begin
            if (lowest[p]) begin
                pos = pos | OFF_W'(p);
            end
        end
    end

    assign o_res.found = |cand;
    assign o_res.pos   = pos;

endmodule

// ===== rtl/core/grouped_bitmap_allocator.sv =====
// grouped_bitmap_allocator: first-fit allocator over a grouped bitmap
// depends on gba_pkg, gba_ram, gba_find
//
// usage: a request is taken when start is high and busy is low. i_func
// selects allocate (first clear bit, group 0 skips the reserved bits) or
// free of i_target_number. each request gives exactly one result, shown for
// one cycle with o_done high; the receiver cannot hold it off.
// configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index at once
// (0 bits per group, 1 group count, 2 reserved in group 0, 3 number base);
// write only while busy is low and no result is pending.
// operation: a free walks one group per cycle to find its group, then reads
// the bitmap word and the group counter; a free below the number base, or
// with zero bits per group or zero groups, is answered straight from idle.
// an allocate reads one 64-bit bitmap word per cycle from the single bitmap
// port, going back through the seek state at each group change; 128 words
// per group at the default size.
// one request is in work at a time; start is taken in the cycle a result
// is shown.
// reset: a clearing pass writes every bitmap word and counter to zero, with
// busy high; configuration writes are still taken.

module grouped_bitmap_allocator
    import gba_pkg::*;
#(
    parameter int GROUPS     = 16,
    parameter int GROUP_BITS = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [NUM_W-1:0]     i_target_number,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_done,
    output logic [NUM_W-1:0]     o_result_number,
    output logic [STATUS_W-1:0]  o_status,
    output logic [GIDX_W-1:0]    o_group_index,
    output logic [CNT_W-1:0]     o_group_free
);

    localparam int WORDS = (GROUPS * GROUP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDXW  = AW + OFF_W;
    localparam int GCW   = $clog2(GROUPS + 1);
    localparam int CAW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CLRN  = (WORDS > GROUPS) ? WORDS : GROUPS;
    localparam int CLW   = (CLRN > 1) ? $clog2(CLRN) : 1;
    localparam int B_W   = BPG_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SEEK,
        S_A_CHK,
        S_A_CNT,
        S_F_DIV,
        S_F_CHK,
        S_F_CNT
    } t_state;

    t_state r_state;

    logic [BPG_W-1:0]  r_bpg;
    logic [NGRP_W-1:0] r_ngrp;
    logic [BPG_W-1:0]  r_rsvd;
    logic              r_base;

    logic [CLW-1:0]   r_clr;
    logic [GCW-1:0]   r_g;
    logic [B_W-1:0]   r_b;
    logic [IDXW-1:0]  r_ibase;
    logic [NUM_W-1:0] r_gbase;
    logic [NUM_W-1:0] r_n;
    logic [NUM_W-1:0] r_target;
    logic             r_already;

    logic [BPG_W-1:0] eff_bpg;
    logic [GCW-1:0]   eff_ng;
    logic [IDXW-1:0]  cur_idx;
    logic [IDXW-1:0]  step_idx;
    logic [IDXW-1:0]  div_idx;
    logic [OFF_W-1:0] off;
    logic [B_W-1:0]   rem;
    logic [B_W-1:0]   b_found;
    logic [B_W-1:0]   b_step;
    t_find_res        fres;

    logic              bm_we;
    logic [AW-1:0]     bm_addr;
    logic [WORD_W-1:0] bm_wdata;
    logic [WORD_W-1:0] bm_rdata;
    logic              cnt_we;
    logic [CAW-1:0]    cnt_addr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;

    logic [CNT_W-1:0] used_inc;
    logic [CNT_W-1:0] used_dec;
    logic [CNT_W-1:0] used_new;
    logic [CNT_W-1:0] free_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpg  <= BPG_RESET;
            r_ngrp <= NGRP_RESET;
            r_rsvd <= '0;
            r_base <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BITS_PER_GROUP: r_bpg  <= i_cfg_wdata;
                REG_GROUP_COUNT:    r_ngrp <= i_cfg_wdata[NGRP_W-1:0];
                REG_RESERVED:       r_rsvd <= i_cfg_wdata;
                REG_NUMBER_BASE:    r_base <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign eff_bpg = (32'(r_bpg) < GROUP_BITS) ? r_bpg : BPG_W'(GROUP_BITS);
    assign eff_ng  = (32'(r_ngrp) < GROUPS) ? GCW'(r_ngrp) : GCW'(GROUPS);

    assign cur_idx  = r_ibase + IDXW'(r_b);
    assign off      = cur_idx[OFF_W-1:0];
    assign rem      = {1'b0, eff_bpg} - r_b;
    assign b_found  = r_b + B_W'(fres.pos) - B_W'(off);
    assign b_step   = r_b + (B_W'(WORD_W) - B_W'(off));
    assign step_idx = r_ibase + IDXW'(b_step);
    assign div_idx  = r_ibase + IDXW'(r_n);

    gba_find u_find (
        .i_word (bm_rdata),
        .i_off  (off),
        .i_rem  (rem),
        .o_res  (fres)
    );

    assign used_inc = (cnt_rdata < CNT_MAX) ? cnt_rdata + CNT_W'(1) : cnt_rdata;
    assign used_dec = (cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : cnt_rdata;
    assign used_new = (r_state == S_A_CNT) ? used_inc : (r_already ? cnt_rdata : used_dec);
    assign free_new = (used_new >= eff_bpg) ? '0 : eff_bpg - used_new;

    always_comb begin
        bm_we     = 1'b0;
        bm_addr   = cur_idx[IDXW-1:OFF_W];
        bm_wdata  = bm_rdata;
        cnt_we    = 1'b0;
        cnt_addr  = r_g[CAW-1:0];
        cnt_wdata = used_new;
        unique case (r_state)
            S_CLEAR: begin
                bm_we     = (32'(r_clr) < WORDS);
                bm_addr   = r_clr[AW-1:0];
                bm_wdata  = '0;
                cnt_we    = (32'(r_clr) < GROUPS);
                cnt_addr  = r_clr[CAW-1:0];
                cnt_wdata = '0;
            end
            S_A_CHK: begin
                if (fres.found) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata | (WORD_W'(1) << fres.pos);
                end else begin
                    bm_addr = step_idx[IDXW-1:OFF_W];
                end
            end
            S_A_CNT: begin
                cnt_we = 1'b1;
            end
            S_F_DIV: begin
                bm_addr = div_idx[IDXW-1:OFF_W];
            end
            S_F_CHK: begin
                if (bm_rdata[off]) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata & ~(WORD_W'(1) << off);
                end
            end
            S_F_CNT: begin
                cnt_we = !r_already;
            end
            default: ;
        endcase
    end

    gba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    gba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (GROUPS),
        .AW    (CAW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_addr  (cnt_addr),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLW'(1);
                    if (32'(r_clr) == CLRN - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_g      <= '0;
                    r_ibase  <= '0;
                    r_gbase  <= '0;
                    r_target <= i_target_number;
                    r_n      <= i_target_number - NUM_W'(r_base);
                    r_b      <= {1'b0, r_rsvd};
                    if (start) begin
                        if (i_func == FUNC_ALLOC) begin
                            r_state <= S_A_SEEK;
                        end else if (eff_bpg == '0 || eff_ng == '0
                                     || i_target_number < NUM_W'(r_base)) begin
                            o_done          <= 1'b1;
                            o_status        <= STATUS_RANGE;
                            o_result_number <= '0;
                            o_group_index   <= '0;
                            o_group_free    <= '0;
                        end else begin
                            r_state <= S_F_DIV;
                        end
                    end
                end
                S_A_SEEK: begin
                    if (r_g >= eff_ng) begin
                        o_done          <= 1'b1;
                        o_status        <= STATUS_NO_FREE;
                        o_result_number <= '0;
                        o_group_index   <= '0;
                        o_group_free    <= '0;
                        r_state         <= S_IDLE;
                    end else if (r_b >= B_W'(eff_bpg)) begin
                        r_g     <= r_g + GCW'(1);
                        r_b     <= '0;
                        r_ibase <= r_ibase + IDXW'(GROUP_BITS);
                        r_gbase <= r_gbase + NUM_W'(eff_bpg);
                    end else begin
                        r_state <= S_A_CHK;
                    end
                end
                S_A_CHK: begin
                    if (fres.found) begin
                        r_b     <= b_found;
                        r_state <= S_A_CNT;
                    end else begin
                        r_b <= b_step;
                        if (b_step >= B_W'(eff_bpg)) begin
                            r_state <= S_A_SEEK;
                        end
                    end
                end
                S_A_CNT: begin
                    o_done          <= 1'b1;
                    o_status        <= STATUS_DONE;
                    o_result_number <= r_gbase + NUM_W'(r_b) + NUM_W'(r_base);
                    o_group_index   <= GIDX_W'(r_g);
                    o_group_free    <= free_new;
                    r_state         <= S_IDLE;
                end
                S_F_DIV: begin
                    if (r_g >= eff_ng) begin
                        o_done          <= 1'b1;
                        o_status        <= STATUS_RANGE;
                        o_result_number <= '0;
                        o_group_index   <= '0;
                        o_group_free    <= '0;
                        r_state         <= S_IDLE;
                    end else if (r_n < NUM_W'(eff_bpg)) begin
                        r_b     <= B_W'(r_n);
                        r_state <= S_F_CHK;
                    end else begin
                        r_n     <= r_n - NUM_W'(eff_bpg);
                        r_g     <= r_g + GCW'(1);
                        r_ibase <= r_ibase + IDXW'(GROUP_BITS);
                    end
                end
                S_F_CHK: begin
                    r_already <= !bm_rdata[off];
                    r_state   <= S_F_CNT;
                end
                S_F_CNT: begin
                    o_done          <= 1'b1;
                    o_status        <= r_already ? STATUS_ALREADY_FREE : STATUS_DONE;
                    o_result_number <= r_already ? '0 : r_target;
                    o_group_index   <= GIDX_W'(r_g);
                    o_group_free    <= free_new;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/gba_checker.sv =====
// gba_checker: port level checks for grouped_bitmap_allocator, with its bind
// depends on gba_pkg and the grouped_bitmap_allocator port list

module gba_checker
    import gba_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [NUM_W-1:0]    o_result_number,
    input logic [STATUS_W-1:0] o_status,
    input logic [GIDX_W-1:0]   o_group_index,
    input logic [CNT_W-1:0]    o_group_free
);

    // an accepted request is either in work or answered on the next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted request neither in work nor answered");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == STATUS_NO_FREE || o_status == STATUS_RANGE)
        |-> o_result_number == '0 && o_group_index == '0 && o_group_free == '0)
        else $error("failed request carries nonzero fields");

    a_already_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STATUS_ALREADY_FREE |-> o_result_number == '0)
        else $error("double free returns a number");

endmodule

bind grouped_bitmap_allocator gba_checker u_gba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_result_number (o_result_number),
    .o_status        (o_status),
    .o_group_index   (o_group_index),
    .o_group_free    (o_group_free)
);
